// File: rtl/thrt_pkg.sv
// Package for the thermistor resistance to temperature block.
// Holds the field widths, status codes, the fixed curve ROM contents and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package thrt_pkg;

    // Field widths of the input and result words.
    localparam int OHMS_W     = 32;
    localparam int TYPE_W     = 4;
    localparam int TEMP_W     = 16;
    localparam int OUT_TEMP_W = 15;
    localparam int STATUS_W   = 2;

    // Interpolation arithmetic: temperature difference, quotient and product.
    localparam int DT_W      = TEMP_W + 1;
    localparam int QUO_W     = DT_W;
    localparam int PROD_W    = OHMS_W + DT_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Temperature reported for an unsupported sensor type.
    localparam logic signed [OUT_TEMP_W-1:0] INVALID_TEMP = -15'sd9990;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP  = 2'd0,
        ST_COLD    = 2'd1,
        ST_HOT     = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // One point of a curve: temperature in tenths and resistance in ohms.
    typedef struct packed {
        logic signed [TEMP_W-1:0] tenths;
        logic [OHMS_W-1:0]        ohms;
    } curve_point_t;

    // Curve of sensor type 0, ordered by falling resistance.
    localparam int CURVE_LEN    = 36;
    localparam int CURVE_ADDR_W = $clog2(CURVE_LEN);

    localparam curve_point_t CURVE0 [CURVE_LEN] = '{
        '{-16'sd500, 32'd12177657}, '{-16'sd450, 32'd8014331},
        '{-16'sd400, 32'd5369871},  '{-16'sd350, 32'd3659003},
        '{-16'sd300, 32'd2532873},  '{-16'sd250, 32'd1779515},
        '{-16'sd200, 32'd1267787},  '{-16'sd150, 32'd915155},
        '{-16'sd100, 32'd668841},   '{-16'sd50,  32'd494571},
        '{16'sd0,    32'd369772},   '{16'sd50,   32'd279370},
        '{16'sd100,  32'd213170},   '{16'sd150,  32'd164190},
        '{16'sd200,  32'd127596},   '{16'sd250,  32'd100000},
        '{16'sd300,  32'd79005},    '{16'sd350,  32'd62897},
        '{16'sd400,  32'd50439},    '{16'sd450,  32'd40730},
        '{16'sd500,  32'd33109},    '{16'sd550,  32'd27084},
        '{16'sd600,  32'd22289},    '{16'sd650,  32'd18449},
        '{16'sd700,  32'd15355},    '{16'sd750,  32'd12848},
        '{16'sd800,  32'd10804},    '{16'sd850,  32'd9130},
        '{16'sd900,  32'd7750},     '{16'sd950,  32'd6609},
        '{16'sd1000, 32'd5660},     '{16'sd1050, 32'd4867},
        '{16'sd1100, 32'd4201},     '{16'sd1150, 32'd3641},
        '{16'sd1200, 32'd3166},     '{16'sd1250, 32'd2764}
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic search_step;
        logic fetch;
        logic mul;
        logic div_step;
        logic finish;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic early_done;
        logic search_done;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/thrt_ifs.sv
// Valid/ready channel interfaces for the sample and result words.
// Depends on thrt_pkg for the field widths.
`default_nettype none

interface thrt_in_if import thrt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OHMS_W-1:0]   sense_ohms;
    logic [TYPE_W-1:0]   sensor_type;

    modport source (output valid, output sense_ohms, output sensor_type, input ready);
    modport sink   (input valid, input sense_ohms, input sensor_type, output ready);
endinterface

interface thrt_out_if import thrt_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [OUT_TEMP_W-1:0]  temperature_tenths;
    logic [STATUS_W-1:0]           status;

    modport source (output valid, output temperature_tenths, output status, input ready);
    modport sink   (input valid, input temperature_tenths, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/thrt_ctrl.sv
// Sequencing controller: a one-hot state machine that steps the datapath
// through check, search, fetch, multiply, divide and result. Uses thrt_pkg.
`default_nettype none

module thrt_ctrl import thrt_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_SEARCH = 8'b0000_0100,
        S_FETCH  = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_FIN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_fire;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    // The output register can take a new word when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.early_done ? S_OUT : S_SEARCH;
            end
            S_SEARCH:
            begin
                if (stat.search_done)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted word always starts with the range check.
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_CHECK))
        else $error("accepted word did not move to the check state");

    // A result never overwrites a word still waiting downstream.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("result loaded over an untaken word");

    // A waiting result word stays offered until it is taken.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word withdrawn before it was taken");

    // At most one datapath command is issued in any cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// File: rtl/thrt_dp.sv
// Datapath: curve ROM, range checks, binary search, multiplier, restoring
// divider and the output word register. Uses thrt_pkg.
`default_nettype none

module thrt_dp import thrt_pkg::*; #(
    parameter int TABLE_ENTRIES = 36,
    parameter int SENSOR_TYPES  = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dp_cmd_t                   cmd,
    output dp_stat_t                       stat,
    input  wire logic [OHMS_W-1:0]         in_ohms,
    input  wire logic [TYPE_W-1:0]         in_type,
    output logic signed [OUT_TEMP_W-1:0]   out_temp,
    output logic [STATUS_W-1:0]            out_status
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Curve ROM read; types beyond the first and entries past the curve are zero.
    function automatic curve_point_t rom_read(input logic [TYPE_W-1:0] typ,
                                              input logic [IDX_W-1:0] idx);
        logic [8:0] a;
        a = 9'(idx);
        if ((typ == '0) && (a < 9'(CURVE_LEN)))
        begin
            rom_read = CURVE0[a[CURVE_ADDR_W-1:0]];
        end
        else
        begin
            rom_read = '0;
        end
    endfunction

    logic [OHMS_W-1:0]              r_reg;
    logic [TYPE_W-1:0]              type_reg;
    logic [IDX_W-1:0]               lo_reg;
    logic [IDX_W-1:0]               hi_reg;
    logic signed [TEMP_W-1:0]       t1_reg;
    logic                           neg_reg;
    logic [DT_W-1:0]                dtmag_reg;
    logic [OHMS_W-1:0]              dr_reg;
    logic [OHMS_W-1:0]              den_reg;
    logic [OHMS_W-1:0]              rem_reg;
    logic [QUO_W-1:0]               quo_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic signed [OUT_TEMP_W-1:0]   res_temp_reg;
    logic [STATUS_W-1:0]            res_status_reg;
    logic signed [OUT_TEMP_W-1:0]   out_temp_reg;
    logic [STATUS_W-1:0]            out_status_reg;

    curve_point_t                   e_first;
    curve_point_t                   e_last;
    curve_point_t                   e_mid;
    curve_point_t                   e_hi;
    curve_point_t                   e_lo;
    logic                           is_invalid;
    logic                           is_cold;
    logic                           is_hot;
    logic [IDX_W:0]                 mid_sum;
    logic [IDX_W-1:0]               mid;
    logic [IDX_W-1:0]               span;
    logic signed [DT_W-1:0]         dt;
    logic [PROD_W-1:0]              prod;
    logic [OHMS_W:0]                sh;
    logic [OHMS_W:0]                sh_diff;
    logic                           ge;
    logic signed [QUO_W:0]          q_signed;
    logic signed [TEMP_W+1:0]       final_sum;

    // End point checks for the clamps and the sensor type range.
    assign e_first    = rom_read(type_reg, '0);
    assign e_last     = rom_read(type_reg, LAST_IDX);
    assign is_invalid = {1'b0, type_reg} >= (TYPE_W + 1)'(SENSOR_TYPES);
    assign is_cold    = r_reg >= e_first.ohms;
    assign is_hot     = r_reg <= e_last.ohms;

    // One binary search step: probe the midpoint of the bracket.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign e_mid   = rom_read(type_reg, mid);
    assign span    = hi_reg - lo_reg;

    // Bracketing pair: the hotter entry gives r1 and t1.
    assign e_hi = rom_read(type_reg, hi_reg);
    assign e_lo = rom_read(type_reg, lo_reg);
    assign dt   = DT_W'(e_lo.tenths) - DT_W'(e_hi.tenths);

    // Magnitude product of the temperature step and the resistance offset.
    assign prod = PROD_W'(dtmag_reg) * PROD_W'(dr_reg);

    // Restoring division step: one quotient bit per cycle.
    assign sh      = {rem_reg, quo_reg[QUO_W-1]};
    assign sh_diff = sh - {1'b0, den_reg};
    assign ge      = sh >= {1'b0, den_reg};

    // Apply the sign and add the hotter temperature.
    assign q_signed  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign final_sum = (TEMP_W + 2)'(t1_reg) + (TEMP_W + 2)'(q_signed);

    assign stat.early_done  = is_invalid || is_cold || is_hot;
    assign stat.search_done = span <= IDX_W'(1);
    assign stat.div_done    = cnt_reg == CNT_W'(DIV_STEPS - 1);

    assign out_temp   = out_temp_reg;
    assign out_status = out_status_reg;

    // Division step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Working registers of the current word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg    <= in_ohms;
            type_reg <= in_type;
        end

        if (cmd.check)
        begin
            lo_reg <= '0;
            hi_reg <= LAST_IDX;
            priority if (is_invalid)
            begin
                res_temp_reg   <= INVALID_TEMP;
                res_status_reg <= ST_INVALID;
            end
            else if (is_cold)
            begin
                res_temp_reg   <= e_first.tenths[OUT_TEMP_W-1:0];
                res_status_reg <= ST_COLD;
            end
            else
            begin
                res_temp_reg   <= e_last.tenths[OUT_TEMP_W-1:0];
                res_status_reg <= ST_HOT;
            end
        end
        else if (cmd.search_step)
        begin
            if (r_reg >= e_mid.ohms)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid;
            end
        end

        if (cmd.fetch)
        begin
            t1_reg    <= e_hi.tenths;
            neg_reg   <= dt[DT_W-1];
            dtmag_reg <= dt[DT_W-1] ? DT_W'(-dt) : DT_W'(dt);
            dr_reg    <= r_reg - e_hi.ohms;
            den_reg   <= e_lo.ohms - e_hi.ohms;
        end

        if (cmd.mul)
        begin
            rem_reg <= prod[PROD_W-1:QUO_W];
            quo_reg <= prod[QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? sh_diff[OHMS_W-1:0] : sh[OHMS_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end

        if (cmd.finish)
        begin
            res_temp_reg   <= final_sum[OUT_TEMP_W-1:0];
            res_status_reg <= ST_INTERP;
        end

        if (cmd.emit)
        begin
            out_temp_reg   <= res_temp_reg;
            out_status_reg <= res_status_reg;
        end
    end

`ifndef SYNTHESIS
    // A search step is only taken on a bracket wider than one entry.
    a_search_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_step |-> (lo_reg < hi_reg))
        else $error("search step on a collapsed bracket");

    // The partial remainder stays below the divisor, so the quotient fits.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < den_reg))
        else $error("division remainder not below the divisor");

    // The bracketing pair is only fetched once the search has closed in.
    a_fetch_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> stat.search_done)
        else $error("bracketing pair fetched before the search finished");
`endif

endmodule

`default_nettype wire

// File: rtl/thermistor_resistance_to_temperature_core.sv
// An invalid type or a clamped resistance goes from the check straight to the
// result; otherwise the word passes the binary search, fetch, multiply, the
// 17-step restoring divider and finish. A new word is taken only once the last
// result has been loaded into the output register, so one word at a time; a
// word is accepted while a result still waits. Reset: rst_n is asynchronous,
// active low, and clears the controller and the divide step counter only.
`default_nettype none

module thermistor_resistance_to_temperature_core import thrt_pkg::*; #(
    parameter int TABLE_ENTRIES = 36,
    parameter int SENSOR_TYPES  = 1
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    thrt_in_if.sink     sample,
    thrt_out_if.source  result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller state machine.
    thrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Arithmetic and ROM datapath.
    thrt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SENSOR_TYPES  (SENSOR_TYPES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_ohms    (sample.sense_ohms),
        .in_type    (sample.sensor_type),
        .out_temp   (result.temperature_tenths),
        .out_status (result.status)
    );

endmodule

`default_nettype wire
